// ----- design/bur_pkg.sv -----
package bur_pkg;

  localparam int unsigned CfgBits     = 16;
  localparam logic [CfgBits-1:0] CfgReset = 16'h8000;
  localparam int unsigned QueueDepth  = 4;

  typedef enum logic [2:0] {
    PH_EMPTY = 3'b001,
    PH_ONE   = 3'b010,
    PH_MANY  = 3'b100
  } phase_e;

endpackage

// ----- design/bur_queue.sv -----
module bur_queue #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/bur_front.sv -----
module bur_front #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [DATA_WIDTH-1:0]     in_value_i,
  input  logic                      in_last_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output logic [3*DATA_WIDTH:0]     job_o
);
  import bur_pkg::*;

  localparam int unsigned JobW = 3 * DATA_WIDTH + 1;

  phase_e                phase_q, phase_d;
  logic [DATA_WIDTH-1:0] center_q, center_d, older_q, older_d;
  logic                  pend_q, pend_d;
  logic [JobW-1:0]       pend_job_q, pend_job_d;
  logic                  accept;
  logic                  new_valid;
  logic [JobW-1:0]       new_job;

  assign in_ready_o  = !pend_q && job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = pend_q || (accept && new_valid);
  assign job_o       = pend_q ? pend_job_q : new_job;

  // Each job is packed as {last, right, left, center}.
  always_comb begin
    phase_d    = phase_q;
    center_d   = center_q;
    older_d    = older_q;
    pend_d     = pend_q && !job_ready_i;
    pend_job_d = pend_job_q;
    new_valid  = 1'b0;
    new_job    = {1'b1, in_value_i, in_value_i, in_value_i};
    if (accept) begin
      case (phase_q)
        PH_EMPTY: begin
          if (in_last_i) begin
            new_valid = 1'b1;
          end else begin
            center_d = in_value_i;
            phase_d  = PH_ONE;
          end
        end
        PH_ONE: begin
          new_valid = 1'b1;
          new_job   = {1'b0, in_value_i, in_value_i, center_q};
          older_d   = center_q;
          center_d  = in_value_i;
          phase_d   = PH_MANY;
        end
        default: begin
          new_valid = 1'b1;
          new_job   = {1'b0, in_value_i, older_q, center_q};
          older_d   = center_q;
          center_d  = in_value_i;
          phase_d   = PH_MANY;
        end
      endcase
      if (in_last_i && phase_q != PH_EMPTY) begin
        pend_d     = 1'b1;
        pend_job_d = {1'b1, center_q, center_q, in_value_i};
        phase_d    = PH_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    center_q   <= center_d;
    older_q    <= older_d;
    pend_job_q <= pend_job_d;
  end

endmodule

// ----- design/bur_back.sv -----
module bur_back #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  logic [3*DATA_WIDTH:0]        job_i,
  input  logic [bur_pkg::CfgBits-1:0]  half_courant_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DATA_WIDTH-1:0]        out_value_o,
  output logic                         out_last_o
);
  import bur_pkg::*;

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned MagW  = 2 * DW - 1;
  localparam int unsigned ProdW = MagW + CfgBits;
  localparam int unsigned Shift = FRAC_BITS + CfgBits;
  localparam int unsigned ResW  = ProdW + 2;
  localparam logic [ProdW:0] Half = (ProdW + 1)'(1) << (Shift - 1);
  localparam logic signed [ResW-1:0] MaxV = ResW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [ResW-1:0] MinV = -MaxV - ResW'(1);

  logic                   adv;
  logic signed [DW-1:0]   j_u, j_l, j_r, j_n;
  logic                   j_pos;

  logic                   v1_q, v2_q, v3_q, vo_q;
  logic signed [DW-1:0]   u1_q, u2_q, u3_q;
  logic                   last1_q, last2_q, last3_q, lasto_q;
  logic                   pos1_q;
  logic signed [2*DW-1:0] squ1_q, sqn1_q;
  logic [MagW-1:0]        mag2_q;
  logic                   neg2_q, neg3_q;
  logic [DW+CfgBits-1:0]  plo3_q;
  logic [DW+CfgBits-2:0]  phi3_q;
  logic [DW-1:0]          outv_q;

  logic signed [2*DW:0]   diff;
  logic [2*DW:0]          diff_abs;
  logic [ProdW:0]         full;
  logic [ProdW:0]         term;
  logic signed [ResW-1:0] res;
  logic [DW-1:0]          sat;

  assign adv         = !vo_q || out_ready_i;
  assign job_ready_o = adv;

  assign j_u   = job_i[DW-1:0];
  assign j_l   = job_i[2*DW-1:DW];
  assign j_r   = job_i[3*DW-1:2*DW];
  assign j_pos = !j_u[DW-1] && (j_u != '0);
  assign j_n   = j_pos ? j_l : j_r;

  assign diff     = pos1_q ? ((2*DW+1)'(squ1_q) - (2*DW+1)'(sqn1_q))
                           : ((2*DW+1)'(sqn1_q) - (2*DW+1)'(squ1_q));
  assign diff_abs = diff[2*DW] ? -diff : diff;

  assign full = ((ProdW + 1)'(phi3_q) << DW) + (ProdW + 1)'(plo3_q) + Half;
  assign term = full >> Shift;
  assign res  = neg3_q ? (ResW'(u3_q) + $signed(ResW'(term)))
                       : (ResW'(u3_q) - $signed(ResW'(term)));

  always_comb begin
    if (res > MaxV) begin
      sat = MaxV[DW-1:0];
    end else if (res < MinV) begin
      sat = MinV[DW-1:0];
    end else begin
      sat = res[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= job_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q    <= j_u;
      last1_q <= job_i[3*DW];
      pos1_q  <= j_pos;
      squ1_q  <= j_u * j_u;
      sqn1_q  <= j_n * j_n;

      u2_q    <= u1_q;
      last2_q <= last1_q;
      mag2_q  <= diff_abs[MagW-1:0];
      neg2_q  <= diff[2*DW];

      u3_q    <= u2_q;
      last3_q <= last2_q;
      neg3_q  <= neg2_q;
      plo3_q  <= mag2_q[DW-1:0] * half_courant_i;
      phi3_q  <= mag2_q[MagW-1:DW] * half_courant_i;

      outv_q  <= sat;
      lasto_q <= last3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_value_o = outv_q;
  assign out_last_o  = lasto_q;

endmodule

// ----- design/burgers_upwind_row_update.sv -----
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: cell_value; tlast: last_cell
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: new_value; tlast: row_end
// cfg      in   cfg_valid_i/cfg_ready_o      cfg_data_i: half_courant
//
// One cell is taken per cycle while the queue has room; after a row-end cell the input
// is held while its second request enters the four-entry queue.
// The back end is four register stages sharing one stall; each request passes through
// them in order before its result is presented.
// Reset clears the row phase, the queue and the pipeline, and sets half_courant to 0.5.
// A stalled output freezes the back end; the queue lets the front keep taking cells until it fills.
module burgers_upwind_row_update #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata bits from the lowest: cell_value, zero fill.
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata bits from the lowest: new_value, zero fill.
  output logic [((DATA_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bur_pkg::CfgBits-1:0]      cfg_data_i
);
  import bur_pkg::*;

  localparam int unsigned TdataW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned JobW   = 3 * DATA_WIDTH + 1;

  logic [CfgBits-1:0]    half_courant_q;
  logic                  fq_valid, fq_ready, qb_valid, qb_ready;
  logic [JobW-1:0]       fq_job, qb_job;
  logic [DATA_WIDTH-1:0] out_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_courant_q <= CfgReset;
    end else if (cfg_valid_i) begin
      half_courant_q <= cfg_data_i;
    end
  end

  bur_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[DATA_WIDTH-1:0]),
    .in_last_i   (s_axis_tlast),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  bur_queue #(
    .WIDTH(JobW),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  bur_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (qb_valid),
    .job_ready_o    (qb_ready),
    .job_i          (qb_job),
    .half_courant_i (half_courant_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_value_o    (out_value),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = TdataW'(out_value);

endmodule
